FILE: rtl/core/slir_pkg.sv
// ----------------------------------------------------------------------------
// Sorted list package
// Shared types and codes for the sorted list cell chain.
// ----------------------------------------------------------------------------
`default_nettype none

package slir_pkg;

    localparam int DEFAULT_DEPTH = 32;
    localparam int VAL_W         = 32;

    localparam logic [1:0] ACT_INSERT = 2'd0;
    localparam logic [1:0] ACT_REMOVE = 2'd1;
    localparam logic [1:0] ACT_LIST   = 2'd2;

    localparam logic [2:0] ST_INSERTED = 3'd0;
    localparam logic [2:0] ST_REMOVED  = 3'd1;
    localparam logic [2:0] ST_MISSING  = 3'd2;
    localparam logic [2:0] ST_EMPTY    = 3'd3;
    localparam logic [2:0] ST_FULL     = 3'd4;
    localparam logic [2:0] ST_LISTED   = 3'd5;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_INSERT,
        OP_REMOVE,
        OP_MARK,
        OP_ROTATE
    } t_cell_op;

    typedef struct packed {
        t_cell_op                op;
        logic signed [VAL_W-1:0] val;
    } t_cell_cmd;

    typedef struct packed {
        logic signed [VAL_W-1:0] value;
        logic                    valid;
        logic                    ge;
        logic                    mark;
    } t_cell_link;

endpackage

`default_nettype wire

FILE: rtl/core/sorted_list_insert_remove.sv
// ----------------------------------------------------------------------------
// Sorted list with insert, remove and list
// Ascending list of signed values held in a chain of cells.
// ----------------------------------------------------------------------------
// Insert and remove: result registered in the cycle after the transaction; one
//   transaction per cycle while o_stall is low, set by the compare-and-shift of the cells.
// List: a mark step tags the tail, then one entry per cycle as the chain rotates
//   while i_stall is low; no new transaction is taken until the last entry.
// Reset clears the occupancy flags and control; stored values are not reset.
`default_nettype none

module sorted_list_insert_remove #(
    parameter int DEPTH = slir_pkg::DEFAULT_DEPTH
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire logic [1:0]         i_action,
    input  wire logic signed [31:0] i_value,
    output logic                    o_valid,
    input  wire logic               i_stall,
    output logic [2:0]              o_status,
    output logic signed [31:0]      o_entry_value,
    output logic                    o_last
);
    import slir_pkg::*;

    typedef enum logic {
        S_IDLE,
        S_LIST
    } t_state;

    t_state                  r_state, n_state;
    logic                    r_out_valid, n_out_valid;
    logic [2:0]              r_status, n_status;
    logic signed [VAL_W-1:0] r_entry_value, n_entry_value;
    logic                    r_last, n_last;

    t_cell_cmd               cmd;
    t_cell_link              link [DEPTH];
    t_cell_link              edge_left, edge_right;
    logic [DEPTH-1:0]        eq;
    logic                    found, full, empty, can_load, accept;

    assign edge_left  = '{value: '0, valid: 1'b1, ge: 1'b0, mark: 1'b0};
    assign edge_right = '{value: '0, valid: 1'b0, ge: 1'b0, mark: 1'b0};

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        slir_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_cmd   (cmd),
            .i_left  ((g == 0) ? edge_left : link[(g == 0) ? 0 : g - 1]),
            .i_right ((g == DEPTH - 1) ? edge_right
                                       : link[(g == DEPTH - 1) ? g : g + 1]),
            .i_head  (link[0]),
            .o_link  (link[g]),
            .o_eq    (eq[g])
        );
    end

    assign found    = |eq;
    assign full     = link[DEPTH-1].valid;
    assign empty    = !link[0].valid;
    assign can_load = !r_out_valid || !i_stall;
    assign o_stall  = !((r_state == S_IDLE) && can_load);
    assign accept   = i_valid && !o_stall;

    always_comb begin
        cmd.op        = OP_NONE;
        cmd.val       = i_value;
        n_state       = r_state;
        n_out_valid   = r_out_valid && i_stall;
        n_status      = r_status;
        n_entry_value = r_entry_value;
        n_last        = r_last;
        if (accept) begin
            n_entry_value = i_value;
            n_last        = 1'b1;
            unique case (i_action)
                ACT_INSERT: begin
                    n_out_valid = 1'b1;
                    if (full) begin
                        n_status = ST_FULL;
                    end else begin
                        cmd.op   = OP_INSERT;
                        n_status = ST_INSERTED;
                    end
                end
                ACT_REMOVE: begin
                    n_out_valid = 1'b1;
                    if (empty) begin
                        n_status = ST_EMPTY;
                    end else if (!found) begin
                        n_status = ST_MISSING;
                    end else begin
                        cmd.op   = OP_REMOVE;
                        n_status = ST_REMOVED;
                    end
                end
                ACT_LIST: begin
                    if (empty) begin
                        n_out_valid = 1'b1;
                        n_status    = ST_EMPTY;
                    end else begin
                        cmd.op  = OP_MARK;
                        n_state = S_LIST;
                    end
                end
                default: begin
                end
            endcase
        end else if ((r_state == S_LIST) && can_load) begin
            cmd.op        = OP_ROTATE;
            n_out_valid   = 1'b1;
            n_status      = ST_LISTED;
            n_entry_value = link[0].value;
            n_last        = link[0].mark;
            if (link[0].mark) begin
                n_state = S_IDLE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_status      <= n_status;
        r_entry_value <= n_entry_value;
        r_last        <= n_last;
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_status      = r_status;
    assign o_entry_value = r_entry_value;
    assign o_last        = r_last;

endmodule

`default_nettype wire

FILE: rtl/core/slir_cell.sv
// ----------------------------------------------------------------------------
// Sorted list cell
// One list position: holds a value, occupancy and tail mark, shifts with
// its neighbours on insert, remove and list rotation.
// ----------------------------------------------------------------------------
`default_nettype none

module slir_cell (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire slir_pkg::t_cell_cmd     i_cmd,
    input  wire slir_pkg::t_cell_link    i_left,
    input  wire slir_pkg::t_cell_link    i_right,
    input  wire slir_pkg::t_cell_link    i_head,
    output slir_pkg::t_cell_link         o_link,
    output logic                         o_eq
);
    import slir_pkg::*;

    logic signed [VAL_W-1:0] r_value, n_value;
    logic                    r_valid, n_valid;
    logic                    r_mark, n_mark;
    logic                    ge;

    assign ge   = r_valid && (r_value >= i_cmd.val);
    assign o_eq = r_valid && (r_value == i_cmd.val);

    assign o_link.value = r_value;
    assign o_link.valid = r_valid;
    assign o_link.ge    = ge;
    assign o_link.mark  = r_mark;

    always_comb begin
        n_value = r_value;
        n_valid = r_valid;
        n_mark  = r_mark;
        case (i_cmd.op)
            OP_INSERT: begin
                if (i_left.ge) begin
                    n_value = i_left.value;
                end else if (ge || (!r_valid && i_left.valid)) begin
                    n_value = i_cmd.val;
                end
                n_valid = r_valid || i_left.valid;
            end
            OP_REMOVE: begin
                if (ge) begin
                    n_value = i_right.value;
                end
                n_valid = i_right.valid;
            end
            OP_MARK: begin
                n_mark = r_valid && !i_right.valid;
            end
            OP_ROTATE: begin
                if (i_right.valid) begin
                    n_value = i_right.value;
                    n_mark  = i_right.mark;
                end else if (r_valid) begin
                    n_value = i_head.value;
                    n_mark  = i_head.mark;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
        r_mark  <= n_mark;
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

endmodule

`default_nettype wire
